// File: src/unc_pkg.sv
// Package for the unit normal compressor: quantization constants, code layout
// and the control word that travels down the pipeline.
// No dependencies.
package unc_pkg;

    localparam int unsigned QBITS = 7;
    localparam int unsigned CODE_WIDTH = 16;

    localparam logic [QBITS-1:0] QUANT_MAX = 7'd126;
    localparam logic [QBITS-1:0] FOLD_BASE = 7'd127;
    localparam logic [QBITS-1:0] FOLD_LIMIT = 7'd64;

    typedef logic [QBITS-1:0] quant_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] neg;
        logic       zero;
    } unc_ctrl_t;

endpackage

// File: src/unc_if.sv
// Request channels of the unit normal compressor: the vector input and the
// code output, each with valid, ready and payload. Depends on nothing.
interface unc_in_if #(
    parameter int unsigned W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] x_value;
    logic signed [W-1:0] y_value;
    logic signed [W-1:0] z_value;

    modport source (output valid, output x_value, output y_value, output z_value,
                    input ready);
    modport sink (input valid, input x_value, input y_value, input z_value,
                  output ready);
endinterface

interface unc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] packed_code;
    logic        zero_vector;

    modport source (output valid, output packed_code, output zero_vector, input ready);
    modport sink (input valid, input packed_code, input zero_vector, output ready);
endinterface

// File: src/unc_prep.sv
// Front of the pipeline: sign split and magnitudes, then the sum of the
// magnitudes and the scaled numerators. Two register stages. Uses unc_pkg.
module unc_prep #(
    parameter int unsigned W = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [W-1:0]             x_value,
    input  logic [W-1:0]             y_value,
    input  logic [W-1:0]             z_value,
    output unc_pkg::unc_ctrl_t       ctrl,
    output logic [W:0]               den,
    output logic [W+6:0]             num_x,
    output logic [W+6:0]             num_y
);
    import unc_pkg::*;

    localparam int unsigned RW = W + 7;

    logic             valid_a_reg;
    logic [2:0]       neg_a_reg;
    logic [W-1:0]     mag_x_reg, mag_y_reg, mag_z_reg;
    logic [W-1:0]     mag_x_next, mag_y_next, mag_z_next;
    unc_ctrl_t        ctrl_reg, ctrl_next;
    logic [W:0]       den_reg, den_next;
    logic [RW-1:0]    num_x_reg, num_y_reg, num_x_next, num_y_next;
    logic [RW-1:0]    ext_x, ext_y;

    always_comb
    begin
        mag_x_next = x_value[W-1] ? (~x_value + 1'b1) : x_value;
        mag_y_next = y_value[W-1] ? (~y_value + 1'b1) : y_value;
        mag_z_next = z_value[W-1] ? (~z_value + 1'b1) : z_value;
    end

    // Numerator is 126 times the magnitude, formed as 128m - 2m.
    always_comb
    begin
        ext_x = {{(RW-W){1'b0}}, mag_x_reg};
        ext_y = {{(RW-W){1'b0}}, mag_y_reg};
        num_x_next = (ext_x << 7) - (ext_x << 1);
        num_y_next = (ext_y << 7) - (ext_y << 1);
        den_next = {1'b0, mag_x_reg} + {1'b0, mag_y_reg} + {1'b0, mag_z_reg};
        ctrl_next.valid = valid_a_reg;
        ctrl_next.neg = neg_a_reg;
        ctrl_next.zero = (den_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg <= {x_value[W-1], y_value[W-1], z_value[W-1]};
            mag_x_reg <= mag_x_next;
            mag_y_reg <= mag_y_next;
            mag_z_reg <= mag_z_next;
            den_reg <= den_next;
            num_x_reg <= num_x_next;
            num_y_reg <= num_y_next;
        end
    end

    assign ctrl = ctrl_reg;
    assign den = den_reg;
    assign num_x = num_x_reg;
    assign num_y = num_y_reg;

endmodule

// File: src/unc_div_step.sv
// One restoring division stage: resolves quotient bit BIT for the x and y
// lanes against the shared divisor. Uses unc_pkg.
module unc_div_step #(
    parameter int unsigned W   = 16,
    parameter int unsigned BIT = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  unc_pkg::unc_ctrl_t  ctrl_in,
    input  logic [W:0]          den_in,
    input  logic [W+6:0]        rem_x_in,
    input  logic [W+6:0]        rem_y_in,
    input  unc_pkg::quant_t     q_x_in,
    input  unc_pkg::quant_t     q_y_in,
    output unc_pkg::unc_ctrl_t  ctrl_out,
    output logic [W:0]          den_out,
    output logic [W+6:0]        rem_x_out,
    output logic [W+6:0]        rem_y_out,
    output unc_pkg::quant_t     q_x_out,
    output unc_pkg::quant_t     q_y_out
);
    import unc_pkg::*;

    localparam int unsigned RW = W + 7;

    unc_ctrl_t     ctrl_reg;
    logic [W:0]    den_reg;
    logic [RW-1:0] rem_x_reg, rem_y_reg, rem_x_next, rem_y_next;
    quant_t        q_x_reg, q_y_reg, q_x_next, q_y_next;
    logic [RW:0]   dshift;
    logic          take_x, take_y;

    always_comb
    begin
        dshift = {{(RW-W){1'b0}}, den_in} << BIT;
        take_x = ({1'b0, rem_x_in} >= dshift);
        take_y = ({1'b0, rem_y_in} >= dshift);
        rem_x_next = take_x ? (rem_x_in - dshift[RW-1:0]) : rem_x_in;
        rem_y_next = take_y ? (rem_y_in - dshift[RW-1:0]) : rem_y_in;
        q_x_next = q_x_in;
        q_y_next = q_y_in;
        q_x_next[BIT] = take_x;
        q_y_next[BIT] = take_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= den_in;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            q_x_reg <= q_x_next;
            q_y_reg <= q_y_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign den_out = den_reg;
    assign rem_x_out = rem_x_reg;
    assign rem_y_out = rem_y_reg;
    assign q_x_out = q_x_reg;
    assign q_y_out = q_y_reg;

endmodule

// File: src/unc_pack.sv
// Last stage: clamps the quotients, folds the triangle and packs the 16-bit
// code into the output register. Uses unc_pkg and unc_out_if.
module unc_pack (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  unc_pkg::unc_ctrl_t ctrl,
    input  unc_pkg::quant_t    q_x,
    input  unc_pkg::quant_t    q_y,
    unc_out_if.source          code
);
    import unc_pkg::*;

    logic        valid_reg;
    logic [15:0] code_reg, code_next;
    logic        zero_reg;
    quant_t      cx, cy, fx, fy;

    always_comb
    begin
        cx = (q_x > QUANT_MAX) ? QUANT_MAX : q_x;
        cy = (q_y > QUANT_MAX) ? QUANT_MAX : q_y;
        if (cx >= FOLD_LIMIT)
        begin
            fx = FOLD_BASE - cx;
            fy = FOLD_BASE - cy;
        end
        else
        begin
            fx = cx;
            fy = cy;
        end
        if (ctrl.zero)
        begin
            code_next = {ctrl.neg, 13'd0};
        end
        else
        begin
            code_next = {ctrl.neg, fx[5:0], fy};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            code_reg <= code_next;
            zero_reg <= ctrl.zero;
        end
    end

    assign code.valid = valid_reg;
    assign code.packed_code = code_reg;
    assign code.zero_vector = zero_reg;

endmodule

// File: src/unit_normal_compress_16bit.sv
// Top level of the unit normal compressor: 16-bit octahedral-style code from
// a signed 3-component vector. Uses unc_pkg, unc_if, unc_prep, unc_div_step, unc_pack.
//
//   Channel  Direction  Payload
//   vec      in         x_value, y_value, z_value (COMPONENT_WIDTH bits, signed)
//   code     out        packed_code (16 bits), zero_vector (1 bit)
//
// One vector is accepted per cycle while the output is not stalled.
// The pipeline holds the unc_prep front stages, seven restoring division stages (one quotient bit each) and unc_pack.
// Reset clears only the valid bits and control words of the pipeline.
// A stalled output freezes the whole pipeline, and the input is not ready then.
module unit_normal_compress_16bit #(
    parameter int unsigned COMPONENT_WIDTH = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    unc_in_if.sink  vec,
    unc_out_if.source code
);
    import unc_pkg::*;

    localparam int unsigned W = COMPONENT_WIDTH;
    localparam int unsigned NSTEP = QBITS;

    logic          en;
    unc_ctrl_t     ctrl_s [0:NSTEP];
    logic [W:0]    den_s  [0:NSTEP];
    logic [W+6:0]  rem_x_s [0:NSTEP];
    logic [W+6:0]  rem_y_s [0:NSTEP];
    quant_t        q_x_s  [0:NSTEP];
    quant_t        q_y_s  [0:NSTEP];

    assign en = !code.valid || code.ready;
    assign vec.ready = en;

    unc_prep #(
        .W (W)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (vec.valid),
        .x_value  (vec.x_value),
        .y_value  (vec.y_value),
        .z_value  (vec.z_value),
        .ctrl     (ctrl_s[0]),
        .den      (den_s[0]),
        .num_x    (rem_x_s[0]),
        .num_y    (rem_y_s[0])
    );

    assign q_x_s[0] = '0;
    assign q_y_s[0] = '0;

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_div
        unc_div_step #(
            .W   (W),
            .BIT (NSTEP - 1 - k)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .ctrl_in   (ctrl_s[k]),
            .den_in    (den_s[k]),
            .rem_x_in  (rem_x_s[k]),
            .rem_y_in  (rem_y_s[k]),
            .q_x_in    (q_x_s[k]),
            .q_y_in    (q_y_s[k]),
            .ctrl_out  (ctrl_s[k+1]),
            .den_out   (den_s[k+1]),
            .rem_x_out (rem_x_s[k+1]),
            .rem_y_out (rem_y_s[k+1]),
            .q_x_out   (q_x_s[k+1]),
            .q_y_out   (q_y_s[k+1])
        );
    end

    unc_pack u_pack (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .ctrl  (ctrl_s[NSTEP]),
        .q_x   (q_x_s[NSTEP]),
        .q_y   (q_y_s[NSTEP]),
        .code  (code)
    );

    // A zero vector carries no signs and no quanta.
    a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
        code.valid && code.zero_vector |-> code.packed_code == 16'd0)
        else $error("zero vector with nonzero code");

    // Unfolded quanta sum to at most 126 and folded ones to at least 128.
    a_fold_split: assert property (@(posedge clk) disable iff (!rst_n)
        code.valid && !code.zero_vector |->
        ({2'b00, code.packed_code[12:7]} + {1'b0, code.packed_code[6:0]}) != 8'd127)
        else $error("quanta violate the fold invariant");

    // Division remainders stay below the divisor after the last step.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_s[NSTEP].valid && !ctrl_s[NSTEP].zero |->
        rem_x_s[NSTEP] < {6'd0, den_s[NSTEP]} && rem_y_s[NSTEP] < {6'd0, den_s[NSTEP]})
        else $error("division remainder out of range");

endmodule

// File: tb/tb_unit_normal_compress_16bit.sv
`timescale 1ns / 1ps
// Testbench for unit_normal_compress_16bit: drives vectors through the request channel
// and checks every code against a hand-worked code or a predictor of the
// octahedral projection. Depends on unc_pkg, unc_if and the compressor's RTL.
module tb_unit_normal_compress_16bit;
    import unc_pkg::*;

    localparam int          RANDOM_VECTORS = 800;
    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          DRAIN_CYCLES   = 30;
    localparam logic [15:0] SIGN_X         = 16'h8000;
    localparam logic [15:0] SIGN_Y         = 16'h4000;
    localparam logic [15:0] SIGN_Z         = 16'h2000;

    typedef struct packed {
        logic [15:0] packed_code;
        logic        zero_vector;
    } code_word_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        golden;
        logic [15:0] golden_code;
        logic        golden_zero;
    } vector_row_t;

    localparam int DIRECTED_ROWS = 19;

    // Rows with golden set carry a hand-worked code; the rest go through the predictor.
    localparam vector_row_t DIRECTED_VECTORS [DIRECTED_ROWS] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b1},
        '{16'h0001, 16'h0000, 16'h0000, 1'b1, 16'h00FF, 1'b0},
        '{16'hFFFF, 16'h0000, 16'h0000, 1'b1, 16'h80FF, 1'b0},
        '{16'h0000, 16'h0001, 16'h0000, 1'b1, 16'h007E, 1'b0},
        '{16'h0000, 16'h0000, 16'h0001, 1'b1, 16'h0000, 1'b0},
        '{16'h0000, 16'h0000, 16'hFFFF, 1'b1, 16'h2000, 1'b0},
        '{16'h8000, 16'h0000, 16'h0000, 1'b1, 16'h80FF, 1'b0},
        '{16'h0000, 16'h8000, 16'h0000, 1'b1, 16'h407E, 1'b0},
        '{16'h0000, 16'h0000, 16'h8000, 1'b1, 16'h2000, 1'b0},
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 16'h152A, 1'b0},
        '{16'h8000, 16'h8000, 16'h8000, 1'b1, 16'hF52A, 1'b0},
        '{16'h0001, 16'h0001, 16'h0000, 1'b1, 16'h1FBF, 1'b0},
        '{16'h0040, 16'h003E, 16'h0000, 1'b1, 16'h1FC1, 1'b0},
        '{16'h7FFF, 16'h8000, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{16'h8000, 16'h7FFF, 16'h0001, 1'b0, 16'h0000, 1'b0},
        '{16'h0000, 16'h7FFF, 16'h8000, 1'b0, 16'h0000, 1'b0},
        '{16'h1234, 16'hEDCC, 16'h0567, 1'b0, 16'h0000, 1'b0},
        '{16'h7FFF, 16'h0001, 16'h0001, 1'b0, 16'h0000, 1'b0},
        '{16'h0003, 16'h0002, 16'h0001, 1'b0, 16'h0000, 1'b0}
    };

    localparam logic [15:0] BOUNDARY_VALUES [6] = '{
        16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF
    };

    logic clk;
    logic rst_n;
    logic no_idle;
    int   mismatches;
    int   vectors_sent;
    int   codes_compared;
    int   zero_codes_seen;
    int   cycle_count;

    code_word_t pending_codes[$];

    unc_in_if #(.W(16)) vec_if ();
    unc_out_if          code_if ();

    unit_normal_compress_16bit #(
        .COMPONENT_WIDTH(16)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vec   (vec_if),
        .code  (code_if)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [16:0] magnitude_of(logic [15:0] v);
        if (v[15])
        begin
            return 17'd0 - {1'b1, v};
        end
        return {1'b0, v};
    endfunction

    function automatic code_word_t predict_code(logic [15:0] x, logic [15:0] y,
                                                logic [15:0] z);
        logic [16:0] ax;
        logic [16:0] ay;
        logic [16:0] az;
        logic [31:0] total;
        logic [31:0] xq;
        logic [31:0] yq;
        code_word_t  word;

        ax = magnitude_of(x);
        ay = magnitude_of(y);
        az = magnitude_of(z);
        total = 32'(ax) + 32'(ay) + 32'(az);
        word.packed_code = (x[15] ? SIGN_X : 16'h0) | (y[15] ? SIGN_Y : 16'h0)
                         | (z[15] ? SIGN_Z : 16'h0);
        word.zero_vector = 1'b0;
        if (total == 32'd0)
        begin
            word.zero_vector = 1'b1;
            return word;
        end
        xq = (32'(QUANT_MAX) * 32'(ax)) / total;
        yq = (32'(QUANT_MAX) * 32'(ay)) / total;
        if (xq > 32'(QUANT_MAX))
        begin
            xq = 32'(QUANT_MAX);
        end
        if (yq > 32'(QUANT_MAX))
        begin
            yq = 32'(QUANT_MAX);
        end
        if (xq >= 32'(FOLD_LIMIT))
        begin
            xq = 32'(FOLD_BASE) - xq;
            yq = 32'(FOLD_BASE) - yq;
        end
        word.packed_code[12:7] = xq[5:0];
        word.packed_code[6:0]  = yq[6:0];
        return word;
    endfunction

    function automatic logic [15:0] signed_small();
        return 16'($urandom_range(0, 30)) - 16'd15;
    endfunction

    function automatic logic [15:0] random_sign(logic [15:0] v);
        return $urandom_range(0, 1) ? 16'd0 - v : v;
    endfunction

    task automatic make_vector(output logic [15:0] x, output logic [15:0] y,
                               output logic [15:0] z);
        int          mode;
        int          lead;
        logic [15:0] scale;
        logic [15:0] split;

        mode = $urandom_range(0, 9);
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
        case (mode)
            4, 5:
            begin
                x = signed_small();
                y = signed_small();
                z = signed_small();
            end
            6:
            begin
                lead = $urandom_range(0, 2);
                if (lead != 0) x = signed_small();
                if (lead != 1) y = signed_small();
                if (lead != 2) z = signed_small();
            end
            7:
            begin
                if ($urandom_range(0, 1)) x = 16'h0000;
                if ($urandom_range(0, 1)) y = 16'h0000;
                if ($urandom_range(0, 1)) z = 16'h0000;
            end
            8:
            begin
                x = BOUNDARY_VALUES[$urandom_range(0, 5)];
                y = BOUNDARY_VALUES[$urandom_range(0, 5)];
                z = BOUNDARY_VALUES[$urandom_range(0, 5)];
            end
            9:
            begin
                // Keep |x| close to half of the magnitude sum, where the fold starts.
                scale = 16'($urandom_range(1, 200));
                split = 16'($urandom_range(0, 62 * scale));
                x = random_sign(16'(64) * scale + 16'($urandom_range(0, 2)) - 16'd1);
                y = random_sign(split);
                z = random_sign(16'(62) * scale - split);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_vector(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z, input code_word_t want);
        int gap;

        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            vec_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vec_if.valid   <= 1'b1;
        vec_if.x_value <= x;
        vec_if.y_value <= y;
        vec_if.z_value <= z;
        @(posedge clk);
        while (!vec_if.ready)
        begin
            @(posedge clk);
        end
        pending_codes.push_back(want);
        vectors_sent++;
    endtask

    initial
    begin
        int          row;
        int          n;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        code_word_t  want;

        rst_n           = 1'b0;
        no_idle         = 1'b0;
        mismatches      = 0;
        vectors_sent    = 0;
        codes_compared  = 0;
        zero_codes_seen = 0;
        vec_if.valid    = 1'b0;
        vec_if.x_value  = '0;
        vec_if.y_value  = '0;
        vec_if.z_value  = '0;
        code_if.ready   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (DIRECTED_VECTORS[row].golden)
            begin
                want.packed_code = DIRECTED_VECTORS[row].golden_code;
                want.zero_vector = DIRECTED_VECTORS[row].golden_zero;
            end
            else
            begin
                want = predict_code(DIRECTED_VECTORS[row].x, DIRECTED_VECTORS[row].y,
                                    DIRECTED_VECTORS[row].z);
            end
            send_vector(DIRECTED_VECTORS[row].x, DIRECTED_VECTORS[row].y,
                        DIRECTED_VECTORS[row].z, want);
        end

        for (n = 0; n < RANDOM_VECTORS; n++)
        begin
            if (n % 50 == 0)
            begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_VECTORS / 2)
            begin
                // Let the pipeline run completely dry once before going on.
                vec_if.valid <= 1'b0;
                @(posedge clk);
                while (pending_codes.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            make_vector(x, y, z);
            send_vector(x, y, z, predict_code(x, y, z));
        end
        vec_if.valid <= 1'b0;

        while (pending_codes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d vectors (%0d directed, %0d random) and compared %0d codes.",
                 vectors_sent, DIRECTED_ROWS, RANDOM_VECTORS, codes_compared);
        $display("Zero vectors seen: %0d; random idle gaps and stalls on both channels.",
                 zero_codes_seen);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        int stall;

        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                code_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            code_if.ready <= 1'b1;
            @(posedge clk);
            while (!code_if.valid)
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        code_word_t want;

        if (rst_n && code_if.valid && code_if.ready)
        begin
            if (pending_codes.size() == 0)
            begin
                $error("Code 0x%04h arrived with no request outstanding",
                       code_if.packed_code);
                mismatches++;
            end
            else
            begin
                want = pending_codes.pop_front();
                codes_compared++;
                if (code_if.zero_vector)
                begin
                    zero_codes_seen++;
                end
                if (code_if.packed_code !== want.packed_code)
                begin
                    $error("packed_code: expected 0x%04h, actual 0x%04h",
                           want.packed_code, code_if.packed_code);
                    mismatches++;
                end
                if (code_if.zero_vector !== want.zero_vector)
                begin
                    $error("zero_vector: expected %0b, actual %0b",
                           want.zero_vector, code_if.zero_vector);
                    mismatches++;
                end
            end
        end
    end

    initial cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out with %0d codes outstanding.", pending_codes.size());
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

// File: unit_normal_compress_16bit.f
src/unc_pkg.sv
src/unc_if.sv
src/unc_prep.sv
src/unc_div_step.sv
src/unc_pack.sv
src/unit_normal_compress_16bit.sv
tb/tb_unit_normal_compress_16bit.sv
